>>> hw/rtl/nfl_pkg.sv
// Package for the name frequency leader block: sizes, payload and link types,
// and helpers that narrow internal values onto the fixed output fields.
// No dependencies.
package nfl_pkg;

    localparam int ENTRIES    = 64;
    localparam int NAME_BYTES = 29;
    localparam int COUNT_BITS = 16;

    localparam int SLOT_BITS = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int POS_BITS  = $clog2(NAME_BYTES + 1);
    localparam int NAME_W    = NAME_BYTES * 8;

    localparam int OUT_SLOT_BITS  = 6;
    localparam int OUT_COUNT_BITS = 16;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    typedef struct packed {
        logic [7:0] name_char;
        logic       name_last;
    } t_in_item;

    typedef struct packed {
        logic [OUT_SLOT_BITS-1:0]  slot;
        logic [OUT_COUNT_BITS-1:0] occurrences;
        logic                      is_new;
        logic                      table_full;
        logic [OUT_SLOT_BITS-1:0]  leader_slot;
        logic [OUT_COUNT_BITS-1:0] leader_count;
    } t_out_item;

    // Completed name traveling down the row of cells.
    typedef struct packed {
        logic                  valid;
        logic                  done;
        logic                  is_new;
        logic [SLOT_BITS-1:0]  slot;
        logic [COUNT_BITS-1:0] count;
        logic [NAME_W-1:0]     name;
    } t_query;

    function automatic logic [OUT_SLOT_BITS-1:0] to_out_slot(
        input logic [SLOT_BITS-1:0] s
    );
        logic [SLOT_BITS+OUT_SLOT_BITS-1:0] w;
        w = {{OUT_SLOT_BITS{1'b0}}, s};
        return w[OUT_SLOT_BITS-1:0];
    endfunction

    function automatic logic [OUT_COUNT_BITS-1:0] to_out_count(
        input logic [COUNT_BITS-1:0] c
    );
        logic [COUNT_BITS+OUT_COUNT_BITS-1:0] w;
        w = {{OUT_COUNT_BITS{1'b0}}, c};
        return w[OUT_COUNT_BITS-1:0];
    endfunction

endpackage

>>> hw/rtl/name_frequency_leader_top.sv
// Name frequency leader: counts distinct names in a row of table cells.
// Throughput: one byte, or one completed name, per cycle while the row advances.
// A result passes through every cell's register and then the output register.
// The row and the output register stall together while a result waits downstream.
// Reset (synchronous, active low) clears the name buffer, all in-use flags,
// the row's valid bits and the leader; no clearing pass is needed.
module name_frequency_leader_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  nfl_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output nfl_pkg::t_out_item o_out_data
);

    // Links between cells; link 0 is fed by the collector, the last one is the tail.
    nfl_pkg::t_query w_link [0:nfl_pkg::ENTRIES];

    logic w_adv;
    logic w_take;

    logic                           r_out_valid;
    nfl_pkg::t_out_item             r_out;
    nfl_pkg::t_out_item             n_out;
    logic [nfl_pkg::SLOT_BITS-1:0]  r_lead_slot;
    logic [nfl_pkg::SLOT_BITS-1:0]  n_lead_slot;
    logic [nfl_pkg::COUNT_BITS-1:0] r_lead_cnt;
    logic [nfl_pkg::COUNT_BITS-1:0] n_lead_cnt;
    logic                           w_lead_upd;

    // Advance the whole row whenever the output register is free or being drained.
    assign w_adv      = !r_out_valid || i_out_ready;
    assign o_in_ready = w_adv;
    assign w_take     = i_in_valid && w_adv;

    nfl_collect u_collect (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (w_take),
        .i_item  (i_in_data),
        .o_q     (w_link[0])
    );

    // Each name walks the row one cell per cycle while the row advances. It hits its
    // matching cell or claims the first free one; names behind it see every earlier
    // update, so results leave the row in arrival order. Stored names stay distinct.
    for (genvar g = 0; g < nfl_pkg::ENTRIES; g++) begin : g_cell
        nfl_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_q     (w_link[g]),
            .o_q     (w_link[g+1])
        );
    end

    // Leader: higher count wins; on a tie the higher (newer) slot wins.
    always_comb begin
        w_lead_upd = w_link[nfl_pkg::ENTRIES].valid && w_link[nfl_pkg::ENTRIES].done
                  && ((w_link[nfl_pkg::ENTRIES].count > r_lead_cnt)
                  || ((w_link[nfl_pkg::ENTRIES].count == r_lead_cnt)
                  && (w_link[nfl_pkg::ENTRIES].slot > r_lead_slot)));
        n_lead_slot = r_lead_slot;
        n_lead_cnt  = r_lead_cnt;
        if (w_lead_upd) begin
            n_lead_slot = w_link[nfl_pkg::ENTRIES].slot;
            n_lead_cnt  = w_link[nfl_pkg::ENTRIES].count;
        end
    end

    // Build the result; a name that left the row unresolved found no room.
    always_comb begin
        n_out = '0;
        if (w_link[nfl_pkg::ENTRIES].done) begin
            n_out.slot        = nfl_pkg::to_out_slot(w_link[nfl_pkg::ENTRIES].slot);
            n_out.occurrences = nfl_pkg::to_out_count(w_link[nfl_pkg::ENTRIES].count);
            n_out.is_new      = w_link[nfl_pkg::ENTRIES].is_new;
        end else begin
            n_out.table_full  = 1'b1;
        end
        n_out.leader_slot  = nfl_pkg::to_out_slot(n_lead_slot);
        n_out.leader_count = nfl_pkg::to_out_count(n_lead_cnt);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_lead_slot <= '0;
            r_lead_cnt  <= '0;
        end else if (w_adv) begin
            r_out_valid <= w_link[nfl_pkg::ENTRIES].valid;
            if (w_link[nfl_pkg::ENTRIES].valid) begin
                r_lead_slot <= n_lead_slot;
                r_lead_cnt  <= n_lead_cnt;
            end
        end
    end

    // Hold the payload until its transfer completes.
    always_ff @(posedge i_clk) begin
        if (w_adv && w_link[nfl_pkg::ENTRIES].valid) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

>>> hw/rtl/nfl_collect.sv
// Byte collector: assembles one zero-padded name from the byte stream and
// launches it into the cell row on its last byte. Depends on nfl_pkg.
module nfl_collect (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_take,
    input  nfl_pkg::t_in_item i_item,
    output nfl_pkg::t_query  o_q
);

    logic [nfl_pkg::NAME_W-1:0]   r_buf;
    logic [nfl_pkg::NAME_W-1:0]   n_buf;
    logic [nfl_pkg::POS_BITS-1:0] r_pos;
    logic [nfl_pkg::POS_BITS-1:0] n_pos;
    logic [nfl_pkg::NAME_W-1:0]   w_name;

    // Merge the current byte at the write position; past the end, ignore it.
    always_comb begin
        for (int b = 0; b < nfl_pkg::NAME_BYTES; b++) begin
            if (r_pos == nfl_pkg::POS_BITS'(b)) begin
                w_name[b*8 +: 8] = i_item.name_char;
            end else begin
                w_name[b*8 +: 8] = r_buf[b*8 +: 8];
            end
        end
    end

    always_comb begin
        n_buf = r_buf;
        n_pos = r_pos;
        if (i_take) begin
            if (i_item.name_last) begin
                n_buf = '0;
                n_pos = '0;
            end else begin
                n_buf = w_name;
                if (r_pos < nfl_pkg::POS_BITS'(nfl_pkg::NAME_BYTES)) begin
                    n_pos = r_pos + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf <= '0;
            r_pos <= '0;
        end else begin
            r_buf <= n_buf;
            r_pos <= n_pos;
        end
    end

    always_comb begin
        o_q        = '0;
        o_q.valid  = i_take && i_item.name_last;
        o_q.name   = w_name;
    end

endmodule

>>> hw/rtl/nfl_cell.sv
// One table cell: holds a stored name and its count, resolves a passing name
// by hit or insert, and hands the name on to the next cell. Depends on nfl_pkg.
module nfl_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_adv,
    input  nfl_pkg::t_query i_q,
    output nfl_pkg::t_query o_q
);

    logic [nfl_pkg::NAME_W-1:0]     r_name;
    logic [nfl_pkg::NAME_W-1:0]     n_name;
    logic [nfl_pkg::COUNT_BITS-1:0] r_count;
    logic [nfl_pkg::COUNT_BITS-1:0] n_count;
    logic                           r_used;
    logic                           n_used;
    nfl_pkg::t_query                r_q;
    nfl_pkg::t_query                n_q;

    always_comb begin
        n_name  = r_name;
        n_count = r_count;
        n_used  = r_used;
        n_q     = i_q;
        if (i_q.valid && !i_q.done) begin
            if (r_used && (r_name == i_q.name)) begin
                // Hit: bump count, saturate at the top.
                if (r_count != nfl_pkg::COUNT_MAX) begin
                    n_count = r_count + 1'b1;
                end
                n_q.done  = 1'b1;
                n_q.count = n_count;
            end else if (!r_used) begin
                // First free cell: claim it.
                n_name     = i_q.name;
                n_count    = nfl_pkg::COUNT_BITS'(1);
                n_used     = 1'b1;
                n_q.done   = 1'b1;
                n_q.is_new = 1'b1;
                n_q.count  = nfl_pkg::COUNT_BITS'(1);
            end else begin
                n_q.slot = i_q.slot + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used  <= 1'b0;
            r_q     <= '0;
        end else if (i_adv) begin
            r_used  <= n_used;
            r_q     <= n_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_name  <= n_name;
            r_count <= n_count;
        end
    end

    assign o_q = r_q;

endmodule

>>> dv/name_frequency_leader_top_tb.sv
// Self-checking testbench for name_frequency_leader_top: streams names byte by byte and
// compares every result with an in-bench tally of names, counts and the leader, or with
// the typed row's want. Depends on nfl_pkg (sizes, payload structs) and the block's RTL.
`timescale 1ns / 100ps

module name_frequency_leader_top_tb;

    localparam int CLK_PERIOD    = 12;
    localparam int RANDOM_ITEMS  = 500;
    localparam int SETTLE_ITEMS  = 40;
    localparam int MAX_NAME_LEN  = nfl_pkg::NAME_BYTES + 5;
    localparam int LONG_HOLD     = 3 * nfl_pkg::ENTRIES;
    localparam int POOL_DEPTH    = 96;
    localparam int HOLD_AT_NAME  = 30;
    localparam int DRAIN_AT_NAME = 70;
    // Generous: many times a run with every idle burst and stall at its longest.
    localparam longint TIMEOUT_NS = 64'd1_000_000;

    typedef enum logic [1:0] {
        PH_DIRECTED,
        PH_RANDOM,
        PH_SETTLE
    } t_run_phase;

    // One row of the directed stimulus; want is used only when typed is set.
    typedef struct {
        nfl_pkg::t_in_item  item;
        bit                 typed;
        nfl_pkg::t_out_item want;
    } t_stim_row;

    // A name as sent on the wire, bytes beyond len unused.
    typedef struct {
        int unsigned                 len;
        logic [MAX_NAME_LEN*8-1:0]   chars;
    } t_name_rec;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    logic               o_in_ready;
    nfl_pkg::t_in_item  i_in_data   = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    nfl_pkg::t_out_item o_out_data;

    name_frequency_leader_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Name tally: the bench's own copy of the table, counts and leader.
    // ------------------------------------------------------------------
    logic [nfl_pkg::NAME_W-1:0]     known_names  [nfl_pkg::ENTRIES];
    logic [nfl_pkg::COUNT_BITS-1:0] known_counts [nfl_pkg::ENTRIES];
    int                             names_in_use = 0;
    logic [nfl_pkg::NAME_W-1:0]     name_acc     = '0;
    int                             acc_pos      = 0;
    int                             lead_slot    = 0;
    logic [nfl_pkg::COUNT_BITS-1:0] lead_count   = '0;

    nfl_pkg::t_out_item expected_tallies [$];
    t_stim_row          dir_rows [$];
    t_name_rec          recent_names [$];
    int                 mismatch_count = 0;
    t_run_phase         run_phase      = PH_DIRECTED;
    bit                 long_hold_req  = 1'b0;
    bit                 in_calm        = 1'b0;
    bit                 out_calm       = 1'b0;

    // Fold one byte into the current name; on the last byte look it up,
    // count or insert it, and report the result the block should give.
    task automatic tally_byte(input nfl_pkg::t_in_item item, output bit produced,
                              output nfl_pkg::t_out_item res);
        int                             hit;
        logic [nfl_pkg::COUNT_BITS-1:0] cnt;
        hit      = -1;
        produced = 1'b0;
        res      = '0;
        if (acc_pos < nfl_pkg::NAME_BYTES) begin
            name_acc[acc_pos*8 +: 8] = item.name_char;
            acc_pos++;
        end
        if (!item.name_last) return;

        produced = 1'b1;
        for (int k = 0; k < names_in_use; k++) begin
            if (known_names[k] == name_acc) begin
                hit = k;
                break;
            end
        end

        if (hit >= 0 || names_in_use < nfl_pkg::ENTRIES) begin
            if (hit >= 0) begin
                if (known_counts[hit] != nfl_pkg::COUNT_MAX) known_counts[hit]++;
            end else begin
                hit               = names_in_use;
                known_names[hit]  = name_acc;
                known_counts[hit] = nfl_pkg::COUNT_BITS'(1);
                names_in_use++;
                res.is_new        = 1'b1;
            end
            cnt = known_counts[hit];
            // Newest slot wins a tie on count.
            if (cnt > lead_count || (cnt == lead_count && hit > lead_slot)) begin
                lead_slot  = hit;
                lead_count = cnt;
            end
            res.slot        = nfl_pkg::OUT_SLOT_BITS'(hit);
            res.occurrences = nfl_pkg::OUT_COUNT_BITS'(cnt);
        end else begin
            res.table_full = 1'b1;
        end
        res.leader_slot  = nfl_pkg::OUT_SLOT_BITS'(lead_slot);
        res.leader_count = nfl_pkg::OUT_COUNT_BITS'(lead_count);

        name_acc = '0;
        acc_pos  = 0;
    endtask

    function automatic nfl_pkg::t_out_item tally_of(int slot, int occ, bit fresh, bit full,
                                                    int lslot, int lcnt);
        nfl_pkg::t_out_item r;
        r.slot         = nfl_pkg::OUT_SLOT_BITS'(slot);
        r.occurrences  = nfl_pkg::OUT_COUNT_BITS'(occ);
        r.is_new       = fresh;
        r.table_full   = full;
        r.leader_slot  = nfl_pkg::OUT_SLOT_BITS'(lslot);
        r.leader_count = nfl_pkg::OUT_COUNT_BITS'(lcnt);
        return r;
    endfunction

    task automatic add_row(input logic [7:0] ch, input bit last, input bit typed,
                           input nfl_pkg::t_out_item want);
        t_stim_row r;
        r.item.name_char = ch;
        r.item.name_last = last;
        r.typed          = typed;
        r.want           = want;
        dir_rows.push_back(r);
    endtask

    // Mostly nonzero bytes; a rare zero byte exercises the padding rule.
    function automatic logic [7:0] pick_char();
        if ($urandom_range(0, 99) < 3) return 8'h00;
        return 8'($urandom_range(1, 255));
    endfunction

    // ------------------------------------------------------------------
    // Sender: one transfer per call, with optional idle burst in front.
    // Valid holds with a stable payload until the edge that accepts it.
    // ------------------------------------------------------------------
    task automatic offer_byte(input nfl_pkg::t_in_item item, input bit typed,
                              input nfl_pkg::t_out_item want);
        bit                 produced;
        nfl_pkg::t_out_item tally;
        if (!in_calm && run_phase != PH_SETTLE && $urandom_range(0, 99) < 25) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        do @(posedge i_clk); while (!o_in_ready);
        tally_byte(item, produced, tally);
        if (produced) expected_tallies.push_back(typed ? want : tally);
        // Flip between idling stretches and clean stretches now and then.
        if ($urandom_range(0, 63) == 0) in_calm = !in_calm;
    endtask

    task automatic send_name(input t_name_rec nm);
        nfl_pkg::t_in_item item;
        for (int k = 0; k < nm.len; k++) begin
            item.name_char = nm.chars[k*8 +: 8];
            item.name_last = (k == nm.len - 1);
            offer_byte(item, 1'b0, '0);
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stall bursts, one long hold on request so the row
    // and the input stall, and no stalls in the settle phase.
    // ------------------------------------------------------------------
    initial begin : sink_side
        forever begin
            @(posedge i_clk);
            if (run_phase == PH_SETTLE) begin
                i_out_ready <= 1'b1;
            end else if (long_hold_req) begin
                long_hold_req = 1'b0;
                i_out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                i_out_ready <= 1'b1;
            end else if (!out_calm && $urandom_range(0, 99) < 25) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= 1'b1;
            end
            if ($urandom_range(0, 63) == 0) out_calm = !out_calm;
        end
    end

    // ------------------------------------------------------------------
    // Result checker: every transfer on the output is compared with the
    // oldest pending tally, field by field.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        nfl_pkg::t_out_item want;
        nfl_pkg::t_out_item got;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = o_out_data;
            if (expected_tallies.size() == 0) begin
                $error("result with no tally pending: slot %0d occurrences %0d",
                       got.slot, got.occurrences);
                mismatch_count++;
            end else begin
                want = expected_tallies.pop_front();
                if (got.slot !== want.slot) begin
                    $error("slot: expected %0d, got %0d", want.slot, got.slot);
                    mismatch_count++;
                end
                if (got.occurrences !== want.occurrences) begin
                    $error("occurrences: expected %0d, got %0d",
                           want.occurrences, got.occurrences);
                    mismatch_count++;
                end
                if (got.is_new !== want.is_new) begin
                    $error("is_new: expected %0d, got %0d", want.is_new, got.is_new);
                    mismatch_count++;
                end
                if (got.table_full !== want.table_full) begin
                    $error("table_full: expected %0d, got %0d",
                           want.table_full, got.table_full);
                    mismatch_count++;
                end
                if (got.leader_slot !== want.leader_slot) begin
                    $error("leader_slot: expected %0d, got %0d",
                           want.leader_slot, got.leader_slot);
                    mismatch_count++;
                end
                if (got.leader_count !== want.leader_count) begin
                    $error("leader_count: expected %0d, got %0d",
                           want.leader_count, got.leader_count);
                    mismatch_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------
    initial begin : main_seq
        t_name_rec   nm;
        int          sent_random;
        int          sent_settle;
        int          names_sent;
        int          new_pct;
        int          pick;
        int          pad;

        // Directed rows. Slot 0 holds the one-byte name 01 and slot 1 the
        // one-byte name FF.
        add_row(8'h01, 1'b1, 1'b1, tally_of(0, 1, 1, 0, 0, 1));
        add_row(8'hFF, 1'b1, 1'b1, tally_of(1, 1, 1, 0, 1, 1));   // tie: newer slot leads
        add_row(8'h01, 1'b1, 1'b1, tally_of(0, 2, 0, 0, 0, 2));
        add_row(8'h80, 1'b0, 1'b0, '0);
        add_row(8'h7F, 1'b1, 1'b1, tally_of(2, 1, 1, 0, 0, 2));
        // Same name with a trailing zero byte must hit slot 2 and take the lead.
        add_row(8'h80, 1'b0, 1'b0, '0);
        add_row(8'h7F, 1'b0, 1'b0, '0);
        add_row(8'h00, 1'b1, 1'b1, tally_of(2, 2, 0, 0, 2, 2));
        // A name made of one zero byte is still a distinct entry.
        add_row(8'h00, 1'b1, 1'b0, '0);
        add_row(8'h55, 1'b0, 1'b0, '0);
        add_row(8'hAA, 1'b0, 1'b0, '0);
        add_row(8'h33, 1'b0, 1'b0, '0);
        add_row(8'hCC, 1'b1, 1'b0, '0);
        add_row(8'hFF, 1'b1, 1'b1, tally_of(1, 2, 0, 0, 2, 2));   // older slot loses tie
        add_row(8'hFF, 1'b1, 1'b1, tally_of(1, 3, 0, 0, 1, 3));

        // Hold reset, then release.
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[k]) offer_byte(dir_rows[k].item, dir_rows[k].typed, dir_rows[k].want);

        // Random part: mostly fresh names until the table is full, then
        // mostly repeats; long names and zero padding mixed in.
        run_phase   = PH_RANDOM;
        sent_random = 0;
        names_sent  = 0;
        while (sent_random < RANDOM_ITEMS) begin
            new_pct = (names_in_use < nfl_pkg::ENTRIES) ? 80 : 35;
            if (recent_names.size() == 0 || $urandom_range(0, 99) < new_pct) begin
                nm.chars = '0;
                pick     = $urandom_range(0, 99);
                if (pick < 80)      nm.len = $urandom_range(1, 2);
                else if (pick < 95) nm.len = $urandom_range(3, 8);
                else                nm.len = $urandom_range(nfl_pkg::NAME_BYTES, MAX_NAME_LEN);
                for (int k = 0; k < nm.len; k++) nm.chars[k*8 +: 8] = pick_char();
                recent_names.push_back(nm);
                if (recent_names.size() > POOL_DEPTH) void'(recent_names.pop_front());
            end else begin
                nm = recent_names[$urandom_range(0, recent_names.size() - 1)];
                if (nm.len >= nfl_pkg::NAME_BYTES) begin
                    // Vary length and bytes past the stored width: still a hit.
                    nm.len = $urandom_range(nfl_pkg::NAME_BYTES, MAX_NAME_LEN);
                    for (int k = nfl_pkg::NAME_BYTES; k < MAX_NAME_LEN; k++)
                        nm.chars[k*8 +: 8] = pick_char();
                end else if (nm.len + 2 <= nfl_pkg::NAME_BYTES
                             && $urandom_range(0, 99) < 15) begin
                    // Append zero bytes: matches the unpadded name.
                    pad = $urandom_range(1, 2);
                    for (int k = 0; k < pad; k++) nm.chars[(nm.len + k)*8 +: 8] = 8'h00;
                    nm.len += pad;
                end
            end

            // Long receiver hold while bytes keep coming.
            if (names_sent == HOLD_AT_NAME) long_hold_req = 1'b1;
            // Sender pause until the block has delivered everything.
            if (names_sent == DRAIN_AT_NAME) begin
                i_in_valid <= 1'b0;
                do @(posedge i_clk); while (expected_tallies.size() != 0);
            end

            send_name(nm);
            sent_random += nm.len;
            names_sent++;
        end

        // Settle phase, no idling on either side: replay known names back to back.
        run_phase   = PH_SETTLE;
        sent_settle = 0;
        while (sent_settle < SETTLE_ITEMS) begin
            nm = recent_names[$urandom_range(0, recent_names.size() - 1)];
            send_name(nm);
            sent_settle += nm.len;
        end

        // Drain and allow the row to empty before judging.
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (expected_tallies.size() != 0);
        repeat (nfl_pkg::ENTRIES + 8) @(posedge i_clk);
        if (mismatch_count == 0) $display("No mismatches found");
        else $display("Mismatches found");
        $finish;
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("Mismatches found");
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/nfl_pkg.sv
hw/rtl/nfl_collect.sv
hw/rtl/nfl_cell.sv
hw/rtl/name_frequency_leader_top.sv
dv/name_frequency_leader_top_tb.sv
